/* rtl/core/dtm_pkg.sv */
// ----------------------------------------------------------------------------
// dtm_pkg: shared types and constants of the depth to top-down map projection
// Holds field widths, register codes and reset values, the queue depths, the
// subsample test and the tangent ROM built at elaboration.
// ----------------------------------------------------------------------------
package dtm_pkg;

  // Fixed design constants.
  localparam int SubsampleStep = 4;
  localparam int TanEntries    = 256;
  localparam int TanIdxW       = $clog2(TanEntries);
  localparam int TanCntW       = $clog2(TanEntries + 1);

  // Field widths.
  localparam int RawW     = 16;
  localparam int ColW     = 12;
  localparam int RowW     = 12;
  localparam int MapColW  = 10;
  localparam int MapRowW  = 10;
  localparam int NearW    = 8;
  localparam int FarW     = 7;
  localparam int ScaleW   = 16;
  localparam int InvW     = 24;
  localparam int RangeW   = 16;
  localparam int MapSizeW = 11;
  localparam int DepthW   = 24;  // millimetres with four fraction bits
  localparam int RelW     = 25;  // relative distance, Q1.24 up to 1.0
  localparam int TanW     = 16;  // signed Q1.15
  localparam int TanMagW  = 15;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgDepthScale  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDepthWidth  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInvWidth    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxRange    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInvMaxRange = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMapWidth    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMapHeight   = 3'd6;

  // Register reset values.
  localparam logic [ScaleW-1:0]   RstDepthScale  = 16'd4096;
  localparam logic [ColW-1:0]     RstDepthWidth  = 12'd640;
  localparam logic [InvW-1:0]     RstInvWidth    = 24'd26214;
  localparam logic [RangeW-1:0]   RstMaxRange    = 16'd4000;
  localparam logic [InvW-1:0]     RstInvMaxRange = 24'd4194;
  localparam logic [MapSizeW-1:0] RstMapWidth    = 11'd640;
  localparam logic [MapSizeW-1:0] RstMapHeight   = 11'd480;
  localparam logic [MapSizeW-1:0] MapSizeMax     = 11'd1024;

  // Arithmetic constants.
  localparam logic [DepthW-1:0] MinRangeQ4 = 24'd3200;  // 200 mm
  localparam logic [RelW-1:0]   RelOne     = 25'h1000000;
  localparam int                NearScale  = 200;
  localparam int                FarScale   = 100;

  // Queue depths.
  localparam int ItemQueueDepth   = 4;
  localparam int ItemPtrW         = $clog2(ItemQueueDepth);
  localparam int ItemCntW         = $clog2(ItemQueueDepth + 1);
  localparam int ResultQueueDepth = 2;
  localparam int ResPtrW          = $clog2(ResultQueueDepth);
  localparam int ResCntW          = $clog2(ResultQueueDepth + 1);

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [ScaleW-1:0]   depth_scale;
    logic [ColW-1:0]     frame_cols;
    logic [InvW-1:0]     inverse_width;
    logic [RangeW-1:0]   max_range_mm;
    logic [InvW-1:0]     inverse_max_range;
    logic [MapSizeW-1:0] map_width;
    logic [MapSizeW-1:0] map_height;
  } cfg_t;

  // A kept pixel on its way to the back end.
  typedef struct packed {
    logic [RawW-1:0] depth_raw;
    logic [ColW-1:0] pixel_column;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_req_t;

  // One map write.
  typedef struct packed {
    logic [MapColW-1:0] map_column;
    logic [MapRowW-1:0] map_row;
    logic [NearW-1:0]   near_level;
    logic [FarW-1:0]    far_level;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t result;
  } res_req_t;

  // Multiple-of-step test by reciprocal multiplication; exact for 12-bit values.
  localparam int     SubShift = 20;
  localparam longint SubRecip = ((64'd1 << SubShift) + SubsampleStep - 1) / SubsampleStep;

  function automatic logic on_step(input logic [ColW-1:0] v);
    logic [32:0]   prod;
    logic [ColW:0] quo;
    logic [16:0]   back;
    prod = 33'(v) * 33'(SubRecip);
    quo  = (ColW + 1)'(prod >> SubShift);
    back = 17'(quo) * 17'(SubsampleStep);
    return back == 17'(v);
  endfunction

  // Tangent ROM: bin centers across a 60 degree field, signed Q1.15.
  typedef logic signed [TanW-1:0] tan_rom_t [TanEntries];

  localparam logic [63:0] Q30One     = 64'd1 << 30;
  localparam longint      PiThirdQ30 = 64'sd1124419809;
  localparam longint      TanBinDiv  = 2 * TanEntries;

  function automatic tan_rom_t tan_rom_build();
    tan_rom_t    rom;
    longint      theta;
    logic        neg;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    for (int i = 0; i < TanEntries; i++) begin
      theta = ((2 * longint'(i) + 1 - longint'(TanEntries)) * PiThirdQ30) / TanBinDiv;
      neg   = theta < 0;
      t     = neg ? 64'(-theta) : 64'(theta);
      t2    = (t * t) >> 30;
      // Sine by Horner steps.
      s = Q30One - (((t2 * Q30One) >> 30) / 110);
      s = Q30One - (((t2 * s) >> 30) / 72);
      s = Q30One - (((t2 * s) >> 30) / 42);
      s = Q30One - (((t2 * s) >> 30) / 20);
      s = Q30One - (((t2 * s) >> 30) / 6);
      s = (t * s) >> 30;
      // Cosine by Horner steps.
      c = Q30One - (((t2 * Q30One) >> 30) / 90);
      c = Q30One - (((t2 * c) >> 30) / 56);
      c = Q30One - (((t2 * c) >> 30) / 30);
      c = Q30One - (((t2 * c) >> 30) / 12);
      c = Q30One - (((t2 * c) >> 30) / 2);
      // Rounded quotient by restoring long division.
      num = (s << 15) + (c >> 1);
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= c) begin
          rem    = rem - c;
          quo[b] = 1'b1;
        end
      end
      rom[i] = neg ? -$signed(quo[TanW-1:0]) : $signed(quo[TanW-1:0]);
    end
    return rom;
  endfunction

  localparam tan_rom_t TanRom = tan_rom_build();

endpackage

/* rtl/core/dtm_front.sv */
// ----------------------------------------------------------------------------
// dtm_front: pixel intake and classification
// Accepts one pixel per cycle while not full, drops pixels off the subsample
// grid, outside the frame or unmeasured; queues the rest for the back end.
// ----------------------------------------------------------------------------
module dtm_front import dtm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            push_i,
  output logic            full_o,
  input  logic [RawW-1:0] depth_raw_i,
  input  logic [ColW-1:0] pixel_column_i,
  input  logic [RowW-1:0] pixel_row_i,
  output item_req_t       item_o,
  input  logic            pop_i
);

  logic [ItemPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ItemPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ItemCntW-1:0] count_q, count_d;
  item_t               mem_q [ItemQueueDepth];
  logic                keep;
  logic                wr_en;
  logic                rd_en;

  // Classify the incoming pixel.
  assign keep = on_step(pixel_row_i) && on_step(pixel_column_i) &&
                (pixel_column_i < cfg_i.frame_cols) && (depth_raw_i != '0);

  assign full_o = (count_q == ItemCntW'(ItemQueueDepth));
  assign wr_en  = push_i && !full_o && keep;
  assign rd_en  = pop_i && (count_q != '0);

  // Queue head toward the back end.
  assign item_o.valid = (count_q != '0);
  assign item_o.item  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == ItemPtrW'(ItemQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == ItemPtrW'(ItemQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= '{depth_raw: depth_raw_i, pixel_column: pixel_column_i};
    end
  end

endmodule

/* rtl/core/dtm_back.sv */
// ----------------------------------------------------------------------------
// dtm_back: projection pipeline
// Five register stages turn a kept pixel into a map write: depth scaling,
// range test and relative distance, tangent lookup, products with the map
// size, and the final placement test on the way into the result queue.
// ----------------------------------------------------------------------------
module dtm_back import dtm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  item_req_t item_i,
  output logic      pop_o,
  output res_req_t  res_o,
  input  logic      res_full_i
);

  localparam int IdxProdW   = ColW + InvW;
  localparam int IdxScaledW = IdxProdW + TanCntW;
  localparam int RProdW     = DepthW + InvW;
  localparam int PW         = RelW + TanMagW;
  localparam int MrowProdW  = RelW + MapSizeW;
  localparam int OffProdW   = PW + MapSizeW;

  logic adv;

  // Stage 1 registers.
  logic                s1_valid_q;
  logic [DepthW-1:0]   s1_depth_q;
  logic [IdxProdW-1:0] s1_iprod_q;
  // Stage 2 registers.
  logic                s2_valid_q;
  logic [RProdW-1:0]   s2_rprod_q;
  logic [TanIdxW-1:0]  s2_idx_q;
  // Stage 3 registers.
  logic                s3_valid_q;
  logic [RelW-1:0]     s3_rel_q;
  logic                s3_neg_q;
  logic [TanMagW-1:0]  s3_mag_q;
  // Stage 4 registers.
  logic                s4_valid_q;
  logic [PW-1:0]       s4_p_q;
  logic [MrowProdW-1:0] s4_mrow_q;
  logic                s4_neg_q;
  logic [NearW-1:0]    s4_near_q;
  logic [FarW-1:0]     s4_far_q;
  // Stage 5 registers.
  logic                s5_valid_q;
  logic [MapSizeW-1:0] s5_off_q;
  logic [MapSizeW-1:0] s5_mrow_q;
  logic                s5_neg_q;
  logic [NearW-1:0]    s5_near_q;
  logic [FarW-1:0]     s5_far_q;

  logic [2*RawW-1:0]     s1_dprod;
  logic [IdxScaledW-1:0] s2_iscaled;
  logic [IdxScaledW-25:0] s2_ihigh;
  logic                  s2_in_range;
  logic [RProdW-5:0]     s3_rshift;
  logic [RelW-1:0]       s3_rel;
  logic signed [TanW-1:0] s3_tan;
  logic [PW-1:0]         s4_p;
  logic [MrowProdW-1:0]  s4_mrow;
  logic [32:0]           s4_near_prod;
  logic [31:0]           s4_far_prod;
  logic [OffProdW-1:0]   s5_off_prod;
  logic signed [MapSizeW+1:0] x;
  logic [MapSizeW-1:0]   half;
  logic                  in_map;

  // The whole pipeline moves together unless the last stage is blocked.
  assign adv   = !s5_valid_q || !res_full_i;
  assign pop_o = adv && item_i.valid;

  // Stage 1: depth in millimetres and the bearing product.
  assign s1_dprod = (2 * RawW)'(item_i.item.depth_raw) * (2 * RawW)'(cfg_i.depth_scale);

  // Stage 2: range test, relative distance product and ROM index.
  assign s2_in_range = (s1_depth_q >= MinRangeQ4) &&
                       (s1_depth_q <= {cfg_i.max_range_mm, 4'b0000});
  assign s2_iscaled  = IdxScaledW'(s1_iprod_q) * IdxScaledW'(TanEntries);
  assign s2_ihigh    = s2_iscaled[IdxScaledW-1:24];

  // Stage 3: saturate relative distance and look up the tangent.
  assign s3_rshift = s2_rprod_q[RProdW-1:4];
  assign s3_rel    = (s3_rshift > (RProdW - 4)'(RelOne)) ? RelOne : s3_rshift[RelW-1:0];
  assign s3_tan    = TanRom[s2_idx_q];

  // Stage 4: products with the map size and the colour levels.
  assign s4_p         = PW'(s3_rel_q) * PW'(s3_mag_q);
  assign s4_mrow      = MrowProdW'(s3_rel_q) * MrowProdW'(cfg_i.map_height);
  assign s4_near_prod = 33'(RelOne - s3_rel_q) * 33'(NearScale);
  assign s4_far_prod  = 32'(s3_rel_q) * 32'(FarScale);

  // Stage 5: lateral offset in map columns.
  assign s5_off_prod = OffProdW'(s4_p_q) * OffProdW'(cfg_i.map_width);

  // Placement on the map, centered on the middle column.
  assign half = {1'b0, cfg_i.map_width[MapSizeW-1:1]};
  assign x    = s5_neg_q ? $signed({2'b00, half}) - $signed({2'b00, s5_off_q})
                         : $signed({2'b00, half}) + $signed({2'b00, s5_off_q});
  assign in_map = !x[MapSizeW+1] && (x[MapSizeW:0] < {1'b0, cfg_i.map_width}) &&
                  (s5_mrow_q < cfg_i.map_height);

  assign res_o.valid             = s5_valid_q && in_map && adv;
  assign res_o.result.map_column = x[MapColW-1:0];
  assign res_o.result.map_row    = s5_mrow_q[MapRowW-1:0];
  assign res_o.result.near_level = s5_near_q;
  assign res_o.result.far_level  = s5_far_q;

  // Valid bits per stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= item_i.valid;
      s2_valid_q <= s1_valid_q && s2_in_range;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_depth_q <= s1_dprod[2*RawW-1:8];
      s1_iprod_q <= IdxProdW'(item_i.item.pixel_column) * IdxProdW'(cfg_i.inverse_width);

      s2_rprod_q <= RProdW'(s1_depth_q) * RProdW'(cfg_i.inverse_max_range);
      s2_idx_q   <= (s2_ihigh > (IdxScaledW - 24)'(TanEntries - 1)) ?
                    TanIdxW'(TanEntries - 1) : s2_ihigh[TanIdxW-1:0];

      s3_rel_q <= s3_rel;
      s3_neg_q <= s3_tan[TanW-1];
      s3_mag_q <= s3_tan[TanW-1] ? TanMagW'(-s3_tan) : s3_tan[TanMagW-1:0];

      s4_p_q    <= s4_p;
      s4_mrow_q <= s4_mrow;
      s4_neg_q  <= s3_neg_q;
      s4_near_q <= s4_near_prod[24+NearW-1:24];
      s4_far_q  <= s4_far_prod[24+FarW-1:24];

      s5_off_q  <= s5_off_prod[OffProdW-1:40];
      s5_mrow_q <= s4_mrow_q[24+MapSizeW-1:24];
      s5_neg_q  <= s4_neg_q;
      s5_near_q <= s4_near_q;
      s5_far_q  <= s4_far_q;
    end
  end

endmodule

/* rtl/core/dtm_result_queue.sv */
// ----------------------------------------------------------------------------
// dtm_result_queue: output queue of map writes
// Holds finished results so the pipeline keeps moving while the consumer
// waits; the oldest result is shown on the outputs while the queue is not
// empty.
// ----------------------------------------------------------------------------
module dtm_result_queue import dtm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  res_req_t res_i,
  output logic     full_o,
  output logic     empty_o,
  input  logic     pop_i,
  output result_t  result_o
);

  logic [ResPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ResPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ResCntW-1:0] count_q, count_d;
  result_t            mem_q [ResultQueueDepth];
  logic               wr_en;
  logic               rd_en;

  assign full_o   = (count_q == ResCntW'(ResultQueueDepth));
  assign empty_o  = (count_q == '0);
  assign wr_en    = res_i.valid && !full_o;
  assign rd_en    = pop_i && !empty_o;
  assign result_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == ResPtrW'(ResultQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == ResPtrW'(ResultQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_i.result;
    end
  end

endmodule

/* rtl/core/depth_to_topdown_map_projection.sv */
// ----------------------------------------------------------------------------
// depth_to_topdown_map_projection: depth pixels to top-down map writes
// Turns a stream of depth pixels into map writes: column, row and two colour
// levels, with subsampling, range gating and a tangent ROM for the bearing.
//
//   Channel   Handshake          Payload
//   input     push / full        depth_raw_i, pixel_column_i, pixel_row_i
//   result    empty / pop        map_column_o, map_row_o, near_level_o,
//                                far_level_o
//   config    cfg_we_i           cfg_index_i, cfg_data_i
//
// One pixel is taken per cycle while full is low; a kept pixel passes the
// pixel queue, the five-stage projection pipeline and the result queue
// before it can be popped.
// Reset loads the register defaults and empties both queues; there is no
// clearing pass.
// A blocked result side fills the two-entry result queue, then stalls the
// pipeline, then fills the four-entry pixel queue, and only then raises full.
// ----------------------------------------------------------------------------
module depth_to_topdown_map_projection import dtm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Pixel input.
  input  logic                push,
  output logic                full,
  input  logic [RawW-1:0]     depth_raw_i,
  input  logic [ColW-1:0]     pixel_column_i,
  input  logic [RowW-1:0]     pixel_row_i,
  // Map writes.
  output logic                empty,
  input  logic                pop,
  output logic [MapColW-1:0]  map_column_o,
  output logic [MapRowW-1:0]  map_row_o,
  output logic [NearW-1:0]    near_level_o,
  output logic [FarW-1:0]     far_level_o,
  // Register writes.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  item_req_t item;
  logic      item_pop;
  res_req_t  res;
  logic      res_full;
  result_t   result;
  logic [MapSizeW-1:0] map_size;

  // Map sizes above the largest map are clamped on write.
  assign map_size = (cfg_data_i[MapSizeW-1:0] > MapSizeMax) ? MapSizeMax
                                                            : cfg_data_i[MapSizeW-1:0];

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDepthScale:  cfg_d.depth_scale       = cfg_data_i[ScaleW-1:0];
        CfgDepthWidth:  cfg_d.frame_cols        = cfg_data_i[ColW-1:0];
        CfgInvWidth:    cfg_d.inverse_width     = cfg_data_i[InvW-1:0];
        CfgMaxRange:    cfg_d.max_range_mm      = cfg_data_i[RangeW-1:0];
        CfgInvMaxRange: cfg_d.inverse_max_range = cfg_data_i[InvW-1:0];
        CfgMapWidth:    cfg_d.map_width         = map_size;
        CfgMapHeight:   cfg_d.map_height        = map_size;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_scale       <= RstDepthScale;
      cfg_q.frame_cols        <= RstDepthWidth;
      cfg_q.inverse_width     <= RstInvWidth;
      cfg_q.max_range_mm      <= RstMaxRange;
      cfg_q.inverse_max_range <= RstInvMaxRange;
      cfg_q.map_width         <= RstMapWidth;
      cfg_q.map_height        <= RstMapHeight;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Intake and classification.
  dtm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .push_i         (push),
    .full_o         (full),
    .depth_raw_i    (depth_raw_i),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .item_o         (item),
    .pop_i          (item_pop)
  );

  // Projection pipeline.
  dtm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (item),
    .pop_o      (item_pop),
    .res_o      (res),
    .res_full_i (res_full)
  );

  // Result queue.
  dtm_result_queue u_result_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_i    (res),
    .full_o   (res_full),
    .empty_o  (empty),
    .pop_i    (pop),
    .result_o (result)
  );

  assign map_column_o = result.map_column;
  assign map_row_o    = result.map_row;
  assign near_level_o = result.near_level;
  assign far_level_o  = result.far_level;

endmodule

/* rtl/core/dtm_checker.sv */
// ----------------------------------------------------------------------------
// dtm_checker: port-level checks of the map projection
// Watches the result side: colour levels stay consistent with one distance,
// and a waiting result is neither lost nor changed.
// ----------------------------------------------------------------------------
module dtm_checker import dtm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input logic [MapColW-1:0]  map_column_o,
  input logic [MapRowW-1:0]  map_row_o,
  input logic [NearW-1:0]    near_level_o,
  input logic [FarW-1:0]     far_level_o
);

  logic [NearW+1:0] level_sum;

  // Both levels come from one distance, so near plus twice far is close to 200.
  assign level_sum = (NearW + 2)'(near_level_o) + (NearW + 2)'({far_level_o, 1'b0});

  a_far_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> far_level_o <= FarW'(FarScale))
    else $error("far level above its scale");

  a_level_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (level_sum >= (NearW + 2)'(NearScale - 2)) &&
               (level_sum <= (NearW + 2)'(NearScale)))
    else $error("near and far levels disagree on distance");

  a_result_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result vanished");

  a_result_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(map_column_o) && $stable(map_row_o) &&
                      $stable(near_level_o) && $stable(far_level_o))
    else $error("waiting result changed");

endmodule

bind depth_to_topdown_map_projection dtm_checker u_dtm_checker (.*);

/* dv/depth_to_topdown_map_projection_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_to_topdown_map_projection_test: self-checking bench of the map block
// Streams depth pixels through the push/full side and drains map writes on
// the empty/pop side, with random idling on both. A tracker projects every
// accepted pixel on its own and compares each drained write field by field.
// The run steps through several register settings, extremes included.
// ----------------------------------------------------------------------------

// Projects pixels onto the map and holds the map writes still to come.
class map_write_tracker;
  longint unsigned depth_scale;
  longint unsigned frame_cols;
  longint unsigned inverse_width;
  longint unsigned max_range_mm;
  longint unsigned inverse_max_range;
  longint unsigned map_width;
  longint unsigned map_height;
  longint signed   tan_table [dtm_pkg::TanEntries];
  dtm_pkg::result_t pending_writes [$];
  int unsigned     error_count;

  function new();
    longint signed   n;
    longint signed   theta;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned s;
    longint unsigned c;
    longint unsigned q;
    bit              neg;
    n = dtm_pkg::TanEntries;
    error_count = 0;
    load_defaults();
    // Tangent of each bin center across the 60 degree field, Q1.15.
    for (int i = 0; i < dtm_pkg::TanEntries; i++) begin
      theta = ((2 * longint'(i) + 1 - n) * 64'sd1124419809) / (2 * n);
      neg   = theta < 0;
      t     = neg ? -theta : theta;
      t2    = (t * t) >> 30;
      s = taylor_term(t2, 64'd1 << 30, 110);
      s = taylor_term(t2, s, 72);
      s = taylor_term(t2, s, 42);
      s = taylor_term(t2, s, 20);
      s = taylor_term(t2, s, 6);
      s = (t * s) >> 30;
      c = taylor_term(t2, 64'd1 << 30, 90);
      c = taylor_term(t2, c, 56);
      c = taylor_term(t2, c, 30);
      c = taylor_term(t2, c, 12);
      c = taylor_term(t2, c, 2);
      q = ((s << 15) + c / 2) / c;
      tan_table[i] = neg ? -longint'(q) : longint'(q);
    end
  endfunction

  // One Horner step of the series: one minus t2 * a / k, in Q2.30.
  function longint unsigned taylor_term(longint unsigned t2, longint unsigned a,
                                        longint unsigned k);
    return (64'd1 << 30) - (((t2 * a) >> 30) / k);
  endfunction

  function void load_defaults();
    depth_scale       = 4096;
    frame_cols        = 640;
    inverse_width     = 26214;
    max_range_mm      = 4000;
    inverse_max_range = 4194;
    map_width         = 640;
    map_height        = 480;
  endfunction

  // Mirrors a register write; map sizes saturate at 1024.
  function void write_register(logic [dtm_pkg::CfgIdxW-1:0] idx,
                               logic [dtm_pkg::CfgDataW-1:0] data);
    case (idx)
      dtm_pkg::CfgDepthScale:  depth_scale       = data[15:0];
      dtm_pkg::CfgDepthWidth:  frame_cols        = data[11:0];
      dtm_pkg::CfgInvWidth:    inverse_width     = data[23:0];
      dtm_pkg::CfgMaxRange:    max_range_mm      = data[15:0];
      dtm_pkg::CfgInvMaxRange: inverse_max_range = data[23:0];
      dtm_pkg::CfgMapWidth: begin
        map_width = data[10:0];
        if (map_width > 1024) map_width = 1024;
      end
      dtm_pkg::CfgMapHeight: begin
        map_height = data[10:0];
        if (map_height > 1024) map_height = 1024;
      end
      default: ;
    endcase
  endfunction

  // Returns 1 and the map write when the pixel lands on the map.
  function bit project_pixel(longint unsigned raw, longint unsigned col,
                             longint unsigned row, output dtm_pkg::result_t res);
    longint unsigned d;
    longint unsigned r;
    longint unsigned idx;
    longint unsigned mag;
    longint unsigned off;
    longint unsigned mrow;
    longint signed   tq;
    longint signed   x;
    res = '0;
    if ((row % dtm_pkg::SubsampleStep) != 0 || (col % dtm_pkg::SubsampleStep) != 0)
      return 0;
    if (col >= frame_cols || raw == 0) return 0;
    // Depth in mm with four fraction bits, gated to the drawn range.
    d = (raw * depth_scale) >> 8;
    if (d < 3200 || d > max_range_mm * 16) return 0;
    r = (d * inverse_max_range) >> 4;
    if (r > (64'd1 << 24)) r = 64'd1 << 24;
    // Bearing bin of the column, clamped to the last entry.
    idx = (col * inverse_width * dtm_pkg::TanEntries) >> 24;
    if (idx > dtm_pkg::TanEntries - 1) idx = dtm_pkg::TanEntries - 1;
    tq  = tan_table[idx];
    mag = (tq < 0) ? -tq : tq;
    off = (r * mag * map_width) >> 40;
    x   = longint'(map_width / 2) + ((tq < 0) ? -longint'(off) : longint'(off));
    mrow = (r * map_height) >> 24;
    if (x < 0 || longint'(map_width) <= x || mrow >= map_height) return 0;
    res.map_column = x[9:0];
    res.map_row    = mrow[9:0];
    d              = (((64'd1 << 24) - r) * 200) >> 24;
    res.near_level = d[7:0];
    d              = (r * 100) >> 24;
    res.far_level  = d[6:0];
    return 1;
  endfunction

  function void note_pixel(longint unsigned raw, longint unsigned col,
                           longint unsigned row);
    dtm_pkg::result_t res;
    if (project_pixel(raw, col, row, res)) pending_writes = {pending_writes, res};
  endfunction

  task report(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task check_write(dtm_pkg::result_t got);
    dtm_pkg::result_t want;
    if (pending_writes.size() == 0) begin
      report($sformatf("unexpected map write col %0d row %0d", got.map_column,
                       got.map_row));
    end else begin
      want = pending_writes.pop_front();
      if (got.map_column !== want.map_column)
        report($sformatf("map_column %0d, want %0d", got.map_column, want.map_column));
      if (got.map_row !== want.map_row)
        report($sformatf("map_row %0d, want %0d", got.map_row, want.map_row));
      if (got.near_level !== want.near_level)
        report($sformatf("near_level %0d, want %0d", got.near_level, want.near_level));
      if (got.far_level !== want.far_level)
        report($sformatf("far_level %0d, want %0d", got.far_level, want.far_level));
    end
  endtask
endclass

module depth_to_topdown_map_projection_test;
  import dtm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;  // past the register list
  localparam int SettleCycles = 32;
  localparam int StallLimit   = 3000;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                push           = 1'b0;
  logic                full;
  logic [RawW-1:0]     depth_raw_i    = '0;
  logic [ColW-1:0]     pixel_column_i = '0;
  logic [RowW-1:0]     pixel_row_i    = '0;
  logic                empty;
  logic                pop            = 1'b0;
  logic [MapColW-1:0]  map_column_o;
  logic [MapRowW-1:0]  map_row_o;
  logic [NearW-1:0]    near_level_o;
  logic [FarW-1:0]     far_level_o;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  bit               calm = 1'b0;
  int unsigned      quiet_cycles = 0;
  map_write_tracker tracker = new();

  depth_to_topdown_map_projection dut (
    .clk_i, .rst_ni, .push, .full, .depth_raw_i, .pixel_column_i, .pixel_row_i,
    .empty, .pop, .map_column_o, .map_row_o, .near_level_o, .far_level_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: pop idles at random except in a calm stretch.
  always @(posedge clk_i) begin
    pop <= calm || ($urandom_range(99) >= 24);
  end

  // Accepted pixel requests feed the tracker; accepted writes are checked.
  always @(posedge clk_i) begin
    dtm_pkg::result_t got;
    if (rst_ni) begin
      if (push && !full) tracker.note_pixel(depth_raw_i, pixel_column_i, pixel_row_i);
      if (pop && !empty) begin
        got.map_column = map_column_o;
        got.map_row    = map_row_o;
        got.near_level = near_level_o;
        got.far_level  = far_level_o;
        tracker.check_write(got);
      end
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("depth_to_topdown_map_projection_test: done, errors");
      $finish;
    end
  end

  task write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.write_register(idx, data);
  endtask

  task apply_settings(logic [CfgDataW-1:0] scale, logic [CfgDataW-1:0] dw,
                      logic [CfgDataW-1:0] invw, logic [CfgDataW-1:0] maxr,
                      logic [CfgDataW-1:0] invmax, logic [CfgDataW-1:0] mw,
                      logic [CfgDataW-1:0] mh);
    write_reg(CfgDepthScale, scale);
    write_reg(CfgDepthWidth, dw);
    write_reg(CfgInvWidth, invw);
    write_reg(CfgMaxRange, maxr);
    write_reg(CfgInvMaxRange, invmax);
    write_reg(CfgMapWidth, mw);
    write_reg(CfgMapHeight, mh);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Fills the bits above a register's width with random junk.
  function logic [CfgDataW-1:0] with_junk(longint unsigned val, int width);
    logic [CfgDataW-1:0] j;
    j = CfgDataW'($urandom);
    return (j << width) | CfgDataW'(val);
  endfunction

  // One pixel request: optional idle cycles, then hold until accepted.
  task send_pixel(logic [RawW-1:0] raw, logic [ColW-1:0] col, logic [RowW-1:0] row);
    while (!calm && $urandom_range(99) < 24) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    depth_raw_i    <= raw;
    pixel_column_i <= col;
    pixel_row_i    <= row;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Mostly pixels that pass every gate, with boundary depths, plus noise.
  task make_pixel(output logic [RawW-1:0] raw, output logic [ColW-1:0] col,
                  output logic [RowW-1:0] row);
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     pick;
    pick = $urandom_range(99);
    raw  = RawW'($urandom);
    col  = ColW'($urandom);
    row  = RowW'($urandom);
    if (pick < 75) begin
      if (tracker.depth_scale != 0) begin
        lo = (3200 * 256 + tracker.depth_scale - 1) / tracker.depth_scale;
        hi = ((tracker.max_range_mm * 16 + 1) * 256 - 1) / tracker.depth_scale;
        if (hi > 65535) hi = 65535;
        if (lo <= hi) begin
          case ($urandom_range(9))
            0:       raw = RawW'(lo);
            1:       raw = RawW'(lo - 1);
            2:       raw = RawW'(hi);
            3:       raw = RawW'(hi + 1);
            default: raw = RawW'($urandom_range(32'(hi), 32'(lo)));
          endcase
        end
      end
      if (tracker.frame_cols != 0)
        col = ColW'($urandom_range(32'((tracker.frame_cols - 1) / SubsampleStep)) *
                    SubsampleStep);
      row = RowW'($urandom_range(1023) * SubsampleStep);
    end else if (pick < 88) begin
      // Broken subsampling on an otherwise plausible pixel.
      row = RowW'(($urandom_range(1023) * SubsampleStep) | $urandom_range(3, 1));
    end
  endtask

  task run_random(int count, int calm_from, int calm_to);
    logic [RawW-1:0] raw;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    for (int i = 0; i < count; i++) begin
      calm = (i >= calm_from) && (i < calm_to);
      make_pixel(raw, col, row);
      send_pixel(raw, col, row);
    end
    calm = 1'b0;
    push <= 1'b0;
  endtask

  // Waits for every expected write, then lets the pipeline run dry.
  task settle();
    @(posedge clk_i);
    while (tracker.pending_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    longint unsigned dw;
    longint unsigned maxr;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels at the reset settings, where one raw unit is one mm.
    send_pixel(16'd0, 12'd0, 12'd0);          // no measurement
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);   // every bit set
    send_pixel(16'd1, 12'd0, 12'd0);          // far too near
    send_pixel(16'd199, 12'd320, 12'd0);      // just short of 200 mm
    send_pixel(16'd200, 12'd320, 12'd0);      // nearest depth kept
    send_pixel(16'd4000, 12'd320, 12'd4092);  // farthest depth kept, last row
    send_pixel(16'd4001, 12'd320, 12'd8);     // just past maximum range
    send_pixel(16'hFFFF, 12'd4, 12'd4);       // largest raw value
    send_pixel(16'd3000, 12'd0, 12'd16);      // leftmost bearing
    send_pixel(16'd3000, 12'd636, 12'd16);    // rightmost bearing
    send_pixel(16'd3000, 12'd640, 12'd16);    // column equal to frame width
    send_pixel(16'd3000, 12'd4092, 12'd16);   // column far past the frame
    send_pixel(16'd3000, 12'd322, 12'd16);    // column off the subsample grid
    send_pixel(16'd3000, 12'd320, 12'd18);    // row off the subsample grid
    send_pixel(16'd3000, 12'd321, 12'd17);    // both off the grid
    send_pixel(16'd1000, 12'd160, 12'd400);
    send_pixel(16'd2500, 12'd480, 12'd4000);
    send_pixel(16'd3999, 12'd316, 12'd4);
    run_random(500, 150, 450);
    settle();

    // Largest sizes and scales.
    apply_settings(65535, 4095, 4097, 65535, 256, 1024, 1024);
    run_random(300, -1, -1);
    settle();

    // Smallest values: the scale is too small for any depth to pass.
    apply_settings(1, 1, 16777215, 200, 83886, 1, 1);
    run_random(40, -1, -1);
    settle();

    // A one-column frame on a one-pixel map.
    apply_settings(65535, 1, 16777215, 200, 83886, 1, 1);
    run_random(60, -1, -1);
    settle();

    // Inconsistent reciprocals: bins and relative distance saturate.
    apply_settings(4096, 640, 16777215, 4000, 8388, 7, 3);
    run_random(100, -1, -1);
    settle();

    // Zero sizes: nothing may come out.
    apply_settings(4096, 0, 4097, 4000, 4194, 0, 0);
    run_random(30, -1, -1);
    settle();

    // Random consistent settings; map sizes may exceed 1024 and saturate.
    for (int p = 0; p < 4; p++) begin
      dw   = $urandom_range(4095, 16);
      maxr = $urandom_range(65535, 200);
      write_reg(CfgSpare, CfgDataW'($urandom));
      apply_settings(with_junk($urandom_range(65535, 16), 16), with_junk(dw, 12),
                     CfgDataW'((64'd1 << 24) / dw), with_junk(maxr, 16),
                     CfgDataW'((64'd1 << 24) / maxr),
                     with_junk($urandom_range(1100, 1), 11),
                     with_junk($urandom_range(1100, 1), 11));
      run_random(200, -1, -1);
      settle();
    end

    if (tracker.error_count == 0) begin
      $display("depth_to_topdown_map_projection_test: done, clean");
    end else begin
      $display("depth_to_topdown_map_projection_test: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/dtm_pkg.sv
rtl/core/dtm_front.sv
rtl/core/dtm_back.sv
rtl/core/dtm_result_queue.sv
rtl/core/depth_to_topdown_map_projection.sv
rtl/core/dtm_checker.sv
dv/depth_to_topdown_map_projection_test.sv
